// ===== sv/pdb_pkg.sv =====
package pdb_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int INV_BITS_PER_CHAN = 5;
    localparam int INV_AW = 3 * INV_BITS_PER_CHAN;
    localparam int INV_DEPTH = 1 << INV_AW;

    localparam logic [6:0] FULL_WEIGHT = 7'd64;
    localparam logic [31:0] ROUND_OR_MASK = 32'h01f0_7c1f;
    localparam int FOLD_SHIFT = 15;

    typedef enum logic [1:0] {
        CMD_LOAD_PAL = 2'd0,
        CMD_LOAD_INV = 2'd1,
        CMD_BLEND    = 2'd2
    } cmd_t;

    typedef enum logic {
        CFG_DIM_WEIGHT = 1'b0,
        CFG_DIM_COLOR  = 1'b1
    } cfg_idx_t;

endpackage

// ===== sv/pdb_mix.sv =====
module pdb_mix (
    input  logic [23:0]                 pix_rgb,
    input  logic [23:0]                 dim_rgb,
    input  logic [6:0]                  weight,
    output logic [pdb_pkg::INV_AW-1:0]  inv_idx
);
    import pdb_pkg::*;

    logic [6:0]  w_pix;
    logic [14:0] pr_r, pr_g, pr_b;
    logic [14:0] dr_r, dr_g, dr_b;
    logic [29:0] pk_pix, pk_dim;
    logic [31:0] sum;
    logic [31:0] folded;

    assign w_pix = FULL_WEIGHT - weight;

    assign pr_r = 15'(pix_rgb[23:16]) * 15'(w_pix);
    assign pr_g = 15'(pix_rgb[15:8])  * 15'(w_pix);
    assign pr_b = 15'(pix_rgb[7:0])   * 15'(w_pix);
    assign dr_r = 15'(dim_rgb[23:16]) * 15'(weight);
    assign dr_g = 15'(dim_rgb[15:8])  * 15'(weight);
    assign dr_b = 15'(dim_rgb[7:0])   * 15'(weight);

    // 10-bit lanes: R at 20, B at 10, G at 0
    assign pk_pix = {pr_r[13:4], pr_b[13:4], pr_g[13:4]};
    assign pk_dim = {dr_r[13:4], dr_b[13:4], dr_g[13:4]};

    assign sum    = (32'(pk_pix) + 32'(pk_dim)) | ROUND_OR_MASK;
    assign folded = sum & (sum >> FOLD_SHIFT);
    assign inv_idx = folded[INV_AW-1:0];

endmodule

// ===== sv/palette_translucent_dim_blend.sv =====
// Palettised translucent dim blend.
// Input channel (in_valid / in_stall) carries one command word: load a palette
// entry, load an inverse colour table byte, or blend a pixel. Loads produce no
// output word; each blend produces one blended_pixel on the output channel
// (out_valid / out_stall).
// A blend accepted into the middle stage moves into the output register when
// that register is empty or being taken. Throughput: one word per cycle while
// out_stall is low; the palette is read at acceptance (two read ports: pixel
// and dim colour), the inverse table is read when the word enters the output register.
// The config port (cfg_wr_en, cfg_index, cfg_data) sets dim_weight and
// dim_color_index; write it only while the block is idle.
// Reset clears the config registers and empties the pipeline. Palette and
// inverse table are not cleared and must be loaded before blending.
// While out_stall is high the output word holds; one more blend may enter the
// middle stage, after which in_stall rises until the output is taken.
module palette_translucent_dim_blend #(
    parameter int PALETTE_SIZE = pdb_pkg::PALETTE_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [7:0]                  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [pdb_pkg::INV_AW-1:0]  index,
    input  logic [23:0]                 load_data,
    input  logic [7:0]                  pixel,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  blended_pixel
);
    import pdb_pkg::*;

    localparam int PAL_AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

    logic [23:0] pal_mem [PALETTE_SIZE];
    logic [7:0]  inv_mem [INV_DEPTH];

    logic [6:0]  dim_weight_reg;
    logic [7:0]  dim_color_reg;

    logic        s1_valid_reg, s1_valid_next;
    logic [6:0]  s1_weight_reg;
    logic [7:0]  s1_pix_reg;
    logic        s1_pix_ok_reg;
    logic        s1_dim_ok_reg;
    logic [23:0] pal_pix_rd_reg;
    logic [23:0] pal_dim_rd_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_zero_reg;
    logic [7:0]  out_pix_reg;
    logic [7:0]  inv_rd_reg;

    logic        adv1;
    logic        in_acc;
    logic        blend_acc;
    logic        pal_wr;
    logic        pix_ok, dim_ok;
    logic [6:0]  w_sat;
    logic [23:0] pix_rgb, dim_rgb;
    logic [INV_AW-1:0] mix_idx;

    assign adv1      = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !adv1;
    assign in_acc    = in_valid && !in_stall;
    assign blend_acc = in_acc && (cmd == CMD_BLEND);
    assign pal_wr    = in_acc && (cmd == CMD_LOAD_PAL)
                       && (index < INV_AW'(PALETTE_SIZE));

    assign pix_ok = {1'b0, pixel} < 9'(PALETTE_SIZE);
    assign dim_ok = {1'b0, dim_color_reg} < 9'(PALETTE_SIZE);
    assign w_sat  = (dim_weight_reg > FULL_WEIGHT) ? FULL_WEIGHT : dim_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_weight_reg <= '0;
            dim_color_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DIM_WEIGHT: dim_weight_reg <= cfg_data[6:0];
                CFG_DIM_COLOR:  dim_color_reg  <= cfg_data;
                default:        dim_weight_reg <= dim_weight_reg;
            endcase
        end
    end

    // palette: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (pal_wr)
        begin
            pal_mem[index[PAL_AW-1:0]] <= load_data;
        end
        if (blend_acc)
        begin
            pal_pix_rd_reg <= pal_mem[pixel[PAL_AW-1:0]];
            pal_dim_rd_reg <= pal_mem[dim_color_reg[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (blend_acc)
        begin
            s1_weight_reg <= w_sat;
            s1_pix_reg    <= pixel;
            s1_pix_ok_reg <= pix_ok;
            s1_dim_ok_reg <= dim_ok;
        end
    end

    assign pix_rgb = s1_pix_ok_reg ? pal_pix_rd_reg : '0;
    assign dim_rgb = s1_dim_ok_reg ? pal_dim_rd_reg : '0;

    pdb_mix u_mix (
        .pix_rgb (pix_rgb),
        .dim_rgb (dim_rgb),
        .weight  (s1_weight_reg),
        .inv_idx (mix_idx)
    );

    // read-first: a table load accepted on the same edge lands after this read
    always_ff @(posedge clk)
    begin
        if (in_acc && (cmd == CMD_LOAD_INV))
        begin
            inv_mem[index] <= load_data[7:0];
        end
        if (adv1 && s1_valid_reg)
        begin
            inv_rd_reg   <= inv_mem[mix_idx];
            out_zero_reg <= (s1_weight_reg == '0);
            out_pix_reg  <= s1_pix_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (blend_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv1)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv1)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign blended_pixel = out_zero_reg ? out_pix_reg : inv_rd_reg;

endmodule
